[rtl/ellipse_span_tracer_assert.svh]
// ----------------------------------------------------------------------------
// Ellipse span tracer assertion macros
// Shared property forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_SPAN_TRACER_ASSERT_SVH
`define ELLIPSE_SPAN_TRACER_ASSERT_SVH

// Condition implies expression in the same cycle.
`define EST_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Condition implies expression in the following cycle.
`define EST_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/est_pkg.sv]
// ----------------------------------------------------------------------------
// est_pkg
// Types, widths and codes shared by the ellipse span tracer modules.
// ----------------------------------------------------------------------------
package est_pkg;

    localparam int AXIS_BITS_DEF = 15;

    localparam int IN_FIELD_W = 16;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 88;
    localparam int COORD_W    = 18;
    localparam int PT_W       = 17;
    localparam int ERR_W      = 48;
    localparam int ALU_W      = 50;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RES_IDX_W  = 2;
    localparam int RES_CNT_W  = 3;

    // s_tdata field positions
    localparam int BOX_LEFT_LSB   = 0;
    localparam int BOX_TOP_LSB    = 16;
    localparam int BOX_WIDTH_LSB  = 32;
    localparam int BOX_HEIGHT_LSB = 48;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic KIND_NONE = 1'b0;
    localparam logic KIND_SPAN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FILL_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COLOR  = 2'd2;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // One point's worth of primitives, handed from the sequencer to the emitter
    typedef struct packed {
        logic               draw;
        logic               fill;
        logic               y_moved;
        logic [PT_W-1:0]    x;
        logic [PT_W-1:0]    y;
        logic [COORD_W-1:0] xc;
        logic [COORD_W-1:0] yc;
        logic [COLOR_W-1:0] color;
        logic               finished;
    } emit_job_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               finished;
        logic               last;
    } span_t;

endpackage

[rtl/est_alu.sv]
// ----------------------------------------------------------------------------
// est_alu
// Shared add/subtract unit for the error-term and increment updates.
// ----------------------------------------------------------------------------
module est_alu
(
    input  logic                       op,
    input  logic [est_pkg::ALU_W-1:0]  op_a,
    input  logic [est_pkg::ALU_W-1:0]  op_b,
    output logic [est_pkg::ALU_W-1:0]  sum
);
    import est_pkg::*;

    logic [ALU_W-1:0] b_eff;

    // subtract as a + ~b + 1
    assign b_eff = (op == ALU_SUB) ? ~op_b : op_b;
    assign sum   = op_a + b_eff + ALU_W'(op == ALU_SUB);

endmodule

[rtl/est_mul.sv]
// ----------------------------------------------------------------------------
// est_mul
// Registered signed-by-unsigned multiplier for the start-up products.
// ----------------------------------------------------------------------------
module est_mul
#(
    parameter int AXIS_BITS = est_pkg::AXIS_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [AXIS_BITS+1:0] op_a,
    input  logic [2*AXIS_BITS-1:0]      op_b,
    output logic [est_pkg::ERR_W-1:0]   prod
);
    import est_pkg::*;

    localparam int FULL_W = 3 * AXIS_BITS + 3;

    logic signed [2*AXIS_BITS:0] b_signed;
    logic signed [FULL_W-1:0]    prod_next;
    logic signed [ERR_W-1:0]     prod_reg;

    assign b_signed  = $signed({1'b0, op_b});
    assign prod_next = op_a * b_signed;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= ERR_W'(prod_next);
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/est_emit.sv]
// ----------------------------------------------------------------------------
// est_emit
// Expands one point into its mirrored spans and drives the result stream.
// ----------------------------------------------------------------------------
module est_emit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  est_pkg::emit_job_t           job,
    output logic                         busy,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [est_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import est_pkg::*;

    function automatic logic [RES_CNT_W-1:0] result_count(emit_job_t j);
        logic [RES_CNT_W-1:0] n;
        n = RES_CNT_W'(1);
        if (j.draw && !(j.fill && !j.y_moved))
        begin
            priority if (j.x == '0 && j.y == '0)
                n = RES_CNT_W'(1);
            else if (j.x == '0)
                n = RES_CNT_W'(2);
            else if (j.y == '0)
                n = j.fill ? RES_CNT_W'(1) : RES_CNT_W'(2);
            else
                n = j.fill ? RES_CNT_W'(2) : RES_CNT_W'(4);
        end
        return n;
    endfunction

    function automatic span_t result_at(emit_job_t j, logic [RES_IDX_W-1:0] idx);
        span_t              r;
        logic [COORD_W-1:0] xw;
        logic [COORD_W-1:0] yw;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        r     = '0;
        xw    = {j.x[PT_W-1], j.x};
        yw    = {j.y[PT_W-1], j.y};
        left  = j.xc - xw;
        right = j.xc + xw;
        lo    = j.yc - yw;
        hi    = j.yc + yw;
        if (j.draw && !(j.fill && !j.y_moved))
        begin
            r.kind  = KIND_SPAN;
            r.color = j.color;
            priority if (j.x == '0 && j.y == '0)
            begin
                r.xs = j.xc;
                r.xe = j.xc;
                r.y  = j.yc;
            end
            else if (j.x == '0)
            begin
                r.xs = j.xc;
                r.xe = j.xc;
                r.y  = idx[0] ? lo : hi;
            end
            else if (j.y == '0)
            begin
                r.y  = j.yc;
                r.xs = (j.fill || !idx[0]) ? left : right;
                r.xe = (j.fill || idx[0]) ? right : left;
            end
            else if (j.fill)
            begin
                r.xs = left;
                r.xe = right;
                r.y  = idx[0] ? hi : lo;
            end
            else
            begin
                r.xs = idx[0] ? right : left;
                r.xe = idx[0] ? right : left;
                r.y  = idx[1] ? lo : hi;
            end
        end
        return r;
    endfunction

    emit_job_t              job_reg;
    logic                   busy_reg;
    logic [RES_IDX_W-1:0]   idx_reg;
    logic                   out_valid_reg;
    span_t                  out_reg;
    span_t                  res;
    logic [RES_IDX_W-1:0]   last_idx;
    logic                   is_last;
    logic                   step_out;

    assign last_idx = RES_IDX_W'(result_count(job_reg) - RES_CNT_W'(1));
    assign is_last  = (idx_reg == last_idx);
    assign step_out = busy_reg && (!out_valid_reg || m_tready);

    always_comb
    begin
        res          = result_at(job_reg, idx_reg);
        res.finished = job_reg.finished;
        res.last     = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (step_out)
            begin
                busy_reg <= !is_last;
                idx_reg  <= idx_reg + RES_IDX_W'(1);
            end

            if (step_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
        if (step_out)
            out_reg <= res;
    end

    assign busy     = busy_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.finished, out_reg.color,
                       out_reg.y, out_reg.xe, out_reg.xs};

endmodule

[rtl/ellipse_span_tracer.sv]
// ----------------------------------------------------------------------------
// ellipse_span_tracer
// Midpoint ellipse tracer: one quadrant traced by an integer error term,
// each point mirrored into horizontal spans or single pixels.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser action; tdata box fields
//  m_*     | out | m_tvalid/m_tready  | tuser kind; tlast last; tdata span
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data (no read-back)
//
//  Step transaction: the single 50-bit adder runs three error candidates,
//  three magnitudes, three compares and two increment updates; the point
//  is then handed over, and 1..4 results follow at one per cycle while
//  m_tready is high. Start transaction: the shared multiplier forms a*a,
//  b*b and (2a-1)*b*b, then hands over; a step with no trace running goes straight to handover.
//  s_tready drops from acceptance until the last result of the transaction
//  is in the output register; the output register holds under m_tready low.
//  Reset is asynchronous, active low, and clears all control state.
// ----------------------------------------------------------------------------
`include "ellipse_span_tracer_assert.svh"

module ellipse_span_tracer
#(
    parameter int AXIS_BITS = est_pkg::AXIS_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [est_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [est_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // box_left[15:0], box_top[31:16], box_width[47:32], box_height[63:48]
    input  logic [est_pkg::S_DATA_W-1:0]   s_tdata,
    // action
    input  logic                           s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // span_x_start[17:0], span_x_end[35:18], span_y[53:36], color[85:54],
    // finished[86], zero pad[87]
    output logic [est_pkg::M_DATA_W-1:0]   m_tdata,
    // kind
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import est_pkg::*;

    localparam int SEMI_W = AXIS_BITS;
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int MOP_W  = AXIS_BITS + 2;
    localparam int HALF_W = IN_FIELD_W - 1;
    localparam logic [HALF_W-1:0] AXIS_LIM = HALF_W'((1 << AXIS_BITS) - 1);

    // sequencer codes
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_MUL_AA  = 5'd1;
    localparam logic [4:0] ST_MUL_BB  = 5'd2;
    localparam logic [4:0] ST_MUL_XI  = 5'd3;
    localparam logic [4:0] ST_MUL_END = 5'd4;
    localparam logic [4:0] ST_FX      = 5'd5;
    localparam logic [4:0] ST_FY      = 5'd6;
    localparam logic [4:0] ST_FXY     = 5'd7;
    localparam logic [4:0] ST_AX      = 5'd8;
    localparam logic [4:0] ST_AY      = 5'd9;
    localparam logic [4:0] ST_AXY     = 5'd10;
    localparam logic [4:0] ST_C1      = 5'd11;
    localparam logic [4:0] ST_C2      = 5'd12;
    localparam logic [4:0] ST_C3      = 5'd13;
    localparam logic [4:0] ST_YI      = 5'd14;
    localparam logic [4:0] ST_XI      = 5'd15;
    localparam logic [4:0] ST_EMIT    = 5'd16;

    function automatic logic [ALU_W-1:0] sx_err(logic [ERR_W-1:0] v);
        return {{(ALU_W-ERR_W){v[ERR_W-1]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] twice_sq(logic [SQ_W-1:0] v);
        return {{(ALU_W-SQ_W-1){1'b0}}, v, 1'b0};
    endfunction

    // configuration registers
    logic               fill_enable_reg;
    logic [COLOR_W-1:0] fill_color_reg;
    logic [COLOR_W-1:0] line_color_reg;

    // trace state
    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic [COORD_W-1:0] center_x_reg;
    logic [COORD_W-1:0] center_y_reg;
    logic [SEMI_W-1:0]  semi_a_reg;
    logic [SEMI_W-1:0]  semi_b_reg;
    logic [SQ_W-1:0]    a_sq_reg;
    logic [SQ_W-1:0]    b_sq_reg;
    logic [ERR_W-1:0]   y_inc_reg;
    logic [ERR_W-1:0]   x_inc_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [PT_W-1:0]    cur_x_reg;
    logic [PT_W-1:0]    cur_y_reg;
    logic               y_moved_reg;
    logic               active_reg;

    // per-step working registers
    logic [ALU_W-1:0]   fx_reg;
    logic [ALU_W-1:0]   fy_reg;
    logic [ALU_W-1:0]   fxy_reg;
    logic [ALU_W-1:0]   ax_reg;
    logic [ALU_W-1:0]   ay_reg;
    logic [ALU_W-1:0]   axy_reg;
    logic               lt_x_xy_reg;
    logic               lt_x_y_reg;
    logic               lt_xy_y_reg;

    // point snapshot for the emitter
    logic               snap_draw_reg;
    logic               snap_fill_reg;
    logic               snap_ym_reg;
    logic [PT_W-1:0]    snap_x_reg;
    logic [PT_W-1:0]    snap_y_reg;
    logic [COLOR_W-1:0] snap_color_reg;

    logic               s_accept;
    logic               act;
    logic [HALF_W-1:0]  half_w;
    logic [HALF_W-1:0]  half_h;
    logic [SEMI_W-1:0]  semi_a_in;
    logic [SEMI_W-1:0]  semi_b_in;
    logic [IN_FIELD_W-1:0] box_left;
    logic [IN_FIELD_W-1:0] box_top;

    logic                    mul_en;
    logic signed [MOP_W-1:0] mul_a;
    logic [SQ_W-1:0]         mul_b;
    logic [ERR_W-1:0]        mul_prod;

    logic               alu_op;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W-1:0]   alu_sum;

    logic               mv_x;
    logic               mv_xy;
    logic [PT_W-1:0]    new_x;
    logic [PT_W-1:0]    new_y;

    logic               emit_load;
    logic               emit_busy;
    emit_job_t          job;

    // ---------------------------------------------------------------- input
    assign s_tready = (state_reg == ST_IDLE) && !emit_busy;
    assign s_accept = s_tvalid && s_tready;
    assign act      = s_tuser;

    assign box_left = s_tdata[BOX_LEFT_LSB +: IN_FIELD_W];
    assign box_top  = s_tdata[BOX_TOP_LSB +: IN_FIELD_W];
    assign half_w   = s_tdata[BOX_WIDTH_LSB + 1 +: HALF_W];
    assign half_h   = s_tdata[BOX_HEIGHT_LSB + 1 +: HALF_W];

    // semi-axes saturate at the widest the datapath carries
    assign semi_a_in = (half_w > AXIS_LIM) ? AXIS_LIM[SEMI_W-1:0] : half_w[SEMI_W-1:0];
    assign semi_b_in = (half_h > AXIS_LIM) ? AXIS_LIM[SEMI_W-1:0] : half_h[SEMI_W-1:0];

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_enable_reg <= 1'b0;
            fill_color_reg  <= '0;
            line_color_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILL_ENABLE: fill_enable_reg <= cfg_data[0];
                REG_FILL_COLOR:  fill_color_reg  <= cfg_data;
                REG_LINE_COLOR:  line_color_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- multiplier
    // a*a, then b*b, then (2a-1)*b*b straight from the product register
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = $signed({2'b00, semi_a_reg});
        mul_b  = SQ_W'(semi_a_reg);
        unique case (state_reg)
            ST_MUL_AA:
            begin
                mul_en = 1'b1;
            end
            ST_MUL_BB:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({2'b00, semi_b_reg});
                mul_b  = SQ_W'(semi_b_reg);
            end
            ST_MUL_XI:
            begin
                mul_en = 1'b1;
                mul_a  = $signed({1'b0, semi_a_reg, 1'b0}) - MOP_W'(1);
                mul_b  = mul_prod[SQ_W-1:0];
            end
            default: ;
        endcase
    end

    est_mul #(
        .AXIS_BITS (AXIS_BITS)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // ---------------------------------------------------------------- adder
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            ST_FX:
            begin
                alu_op = ALU_SUB;
                alu_a  = sx_err(err_reg);
                alu_b  = sx_err(x_inc_reg);
            end
            ST_FY:
            begin
                alu_a = sx_err(err_reg);
                alu_b = sx_err(y_inc_reg);
            end
            ST_FXY:
            begin
                alu_a = fx_reg;
                alu_b = sx_err(y_inc_reg);
            end
            // magnitudes: negate through the adder when the sign is set
            ST_AX:
            begin
                alu_op = fx_reg[ALU_W-1] ? ALU_SUB : ALU_ADD;
                alu_a  = fx_reg[ALU_W-1] ? '0 : fx_reg;
                alu_b  = fx_reg[ALU_W-1] ? fx_reg : '0;
            end
            ST_AY:
            begin
                alu_op = fy_reg[ALU_W-1] ? ALU_SUB : ALU_ADD;
                alu_a  = fy_reg[ALU_W-1] ? '0 : fy_reg;
                alu_b  = fy_reg[ALU_W-1] ? fy_reg : '0;
            end
            ST_AXY:
            begin
                alu_op = fxy_reg[ALU_W-1] ? ALU_SUB : ALU_ADD;
                alu_a  = fxy_reg[ALU_W-1] ? '0 : fxy_reg;
                alu_b  = fxy_reg[ALU_W-1] ? fxy_reg : '0;
            end
            // compares: sign of the difference of two magnitudes
            ST_C1:
            begin
                alu_op = ALU_SUB;
                alu_a  = ax_reg;
                alu_b  = axy_reg;
            end
            ST_C2:
            begin
                alu_op = ALU_SUB;
                alu_a  = ax_reg;
                alu_b  = ay_reg;
            end
            ST_C3:
            begin
                alu_op = ALU_SUB;
                alu_a  = axy_reg;
                alu_b  = ay_reg;
            end
            ST_YI:
            begin
                alu_a = sx_err(y_inc_reg);
                alu_b = twice_sq(a_sq_reg);
            end
            ST_XI:
            begin
                alu_op = ALU_SUB;
                alu_a  = sx_err(x_inc_reg);
                alu_b  = twice_sq(b_sq_reg);
            end
            default: ;
        endcase
    end

    est_alu u_alu (
        .op   (alu_op),
        .op_a (alu_a),
        .op_b (alu_b),
        .sum  (alu_sum)
    );

    // move choice: x alone wins only when strictly best, ties favour y over xy
    assign mv_x  = lt_x_xy_reg && lt_x_y_reg;
    assign mv_xy = !mv_x && lt_xy_y_reg;
    assign new_x = (mv_x || mv_xy) ? cur_x_reg - PT_W'(1) : cur_x_reg;
    assign new_y = mv_x ? cur_y_reg : cur_y_reg + PT_W'(1);

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    priority if (act == ACT_START)
                        state_next = ST_MUL_AA;
                    else if (active_reg)
                        state_next = ST_FX;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_MUL_AA:  state_next = ST_MUL_BB;
            ST_MUL_BB:  state_next = ST_MUL_XI;
            ST_MUL_XI:  state_next = ST_MUL_END;
            ST_MUL_END: state_next = ST_EMIT;
            ST_FX:      state_next = ST_FY;
            ST_FY:      state_next = ST_FXY;
            ST_FXY:     state_next = ST_AX;
            ST_AX:      state_next = ST_AY;
            ST_AY:      state_next = ST_AXY;
            ST_AXY:     state_next = ST_C1;
            ST_C1:      state_next = ST_C2;
            ST_C2:      state_next = ST_C3;
            ST_C3:      state_next = ST_YI;
            ST_YI:      state_next = ST_XI;
            ST_XI:      state_next = ST_EMIT;
            ST_EMIT:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            center_x_reg <= '0;
            center_y_reg <= '0;
            semi_a_reg   <= '0;
            semi_b_reg   <= '0;
            a_sq_reg     <= '0;
            b_sq_reg     <= '0;
            y_inc_reg    <= '0;
            x_inc_reg    <= '0;
            err_reg      <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            y_moved_reg  <= 1'b1;
            active_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (s_accept && act == ACT_START)
            begin
                semi_a_reg   <= semi_a_in;
                semi_b_reg   <= semi_b_in;
                center_x_reg <= {{(COORD_W-IN_FIELD_W){box_left[IN_FIELD_W-1]}}, box_left}
                                + COORD_W'(semi_a_in);
                center_y_reg <= {{(COORD_W-IN_FIELD_W){box_top[IN_FIELD_W-1]}}, box_top}
                                + COORD_W'(semi_b_in);
                err_reg      <= '0;
                cur_x_reg    <= PT_W'(semi_a_in);
                cur_y_reg    <= '0;
                y_moved_reg  <= 1'b1;
                active_reg   <= (semi_a_in != '0) && (semi_b_in != '0);
            end

            unique case (state_reg)
                ST_MUL_BB:
                begin
                    a_sq_reg  <= mul_prod[SQ_W-1:0];
                    y_inc_reg <= mul_prod;
                end
                ST_MUL_XI:
                begin
                    b_sq_reg <= mul_prod[SQ_W-1:0];
                end
                ST_MUL_END:
                begin
                    x_inc_reg <= mul_prod;
                end
                ST_YI:
                begin
                    if (!mv_x)
                        y_inc_reg <= alu_sum[ERR_W-1:0];
                end
                ST_XI:
                begin
                    if (mv_x || mv_xy)
                        x_inc_reg <= alu_sum[ERR_W-1:0];
                    priority if (mv_x)
                        err_reg <= fx_reg[ERR_W-1:0];
                    else if (mv_xy)
                        err_reg <= fxy_reg[ERR_W-1:0];
                    else
                        err_reg <= fy_reg[ERR_W-1:0];
                    cur_x_reg   <= new_x;
                    cur_y_reg   <= new_y;
                    y_moved_reg <= !mv_x;
                    // trace ends once x goes negative or y passes the semi-axis
                    active_reg  <= !(new_x[PT_W-1] || (new_y > PT_W'(semi_b_reg)));
                end
                default: ;
            endcase
        end
    end

    // working registers and point snapshot
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            snap_draw_reg  <= (act == ACT_STEP) && active_reg;
            snap_fill_reg  <= fill_enable_reg;
            snap_ym_reg    <= y_moved_reg;
            snap_x_reg     <= cur_x_reg;
            snap_y_reg     <= cur_y_reg;
            snap_color_reg <= fill_enable_reg ? fill_color_reg : line_color_reg;
        end

        unique case (state_reg)
            ST_FX:   fx_reg      <= alu_sum;
            ST_FY:   fy_reg      <= alu_sum;
            ST_FXY:  fxy_reg     <= alu_sum;
            ST_AX:   ax_reg      <= alu_sum;
            ST_AY:   ay_reg      <= alu_sum;
            ST_AXY:  axy_reg     <= alu_sum;
            ST_C1:   lt_x_xy_reg <= alu_sum[ALU_W-1];
            ST_C2:   lt_x_y_reg  <= alu_sum[ALU_W-1];
            ST_C3:   lt_xy_y_reg <= alu_sum[ALU_W-1];
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- emitter
    assign emit_load = (state_reg == ST_EMIT);

    always_comb
    begin
        job.draw     = snap_draw_reg;
        job.fill     = snap_fill_reg;
        job.y_moved  = snap_ym_reg;
        job.x        = snap_x_reg;
        job.y        = snap_y_reg;
        job.xc       = center_x_reg;
        job.yc       = center_y_reg;
        job.color    = snap_color_reg;
        job.finished = !active_reg;
    end

    est_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit_load),
        .job      (job),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // ---------------------------------------------------------------- checks
    `EST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while previous transaction still in progress")
    `EST_ASSERT_NOW(a_empty_is_single, clk, rst_n, m_tvalid && (m_tuser == KIND_NONE), m_tlast, "empty result not the only result of its transaction")
    `EST_ASSERT_NOW(a_point_in_range, clk, rst_n, active_reg, !cur_x_reg[PT_W-1] && (cur_y_reg <= PT_W'(semi_b_reg)), "running trace point outside quadrant")

endmodule
